// ===== rtl/paci_pkg.sv =====
`timescale 1ns / 1ps
package paci_pkg;

	// fixed field widths
	localparam int COORD_W = 12;
	localparam int MASS_W  = 12;
	localparam int AREA_W  = 31;
	localparam int MOI_W   = 34;
	localparam int CROSS_W = 32;
	localparam int WSUM_W  = 45;
	localparam int DOT_W   = 58;

	// divider sizes: numerator covers mass * dot sum, divisor six times cross sum
	localparam int NUM_W   = 70;
	localparam int DEN_W   = 35;
	localparam int DCNT_W  = 7;

	// divider operand selection
	localparam logic [1:0] DSEL_X = 2'd0;
	localparam logic [1:0] DSEL_Y = 2'd1;
	localparam logic [1:0] DSEL_I = 2'd2;

	typedef struct packed {
		logic       load_vertex;
		logic       close_sel;
		logic       e1;
		logic       e2;
		logic       e3;
		logic       e4;
		logic       e5;
		logic       div_start;
		logic [1:0] div_sel;
		logic       cap_x;
		logic       cap_y;
		logic       mm1;
		logic       mm2;
		logic       cap_i;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic have_vertex;
		logic cross_zero;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/paci_div.sv =====
`timescale 1ns / 1ps
module paci_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [paci_pkg::NUM_W-1:0] num,
	input  logic [paci_pkg::DEN_W-1:0] den,
	output logic                        done,
	output logic [paci_pkg::NUM_W-1:0] quot
);
	import paci_pkg::*;

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DCNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             take;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh  = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
		take    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= take ? rem_sub : rem_sh;
			quot_q <= {quot_q[NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/paci_dp.sv =====
`timescale 1ns / 1ps
module paci_dp #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  paci_pkg::cmd_t                cmd,
	output paci_pkg::stat_t               stat,
	input  logic [paci_pkg::COORD_W-1:0]  vx,
	input  logic [paci_pkg::COORD_W-1:0]  vy,
	input  logic                          cfg_we,
	input  logic [paci_pkg::MASS_W-1:0]   cfg_mass,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [paci_pkg::AREA_W-1:0]   area_half_units,
	output logic [paci_pkg::COORD_W-1:0]  centroid_x,
	output logic [paci_pkg::COORD_W-1:0]  centroid_y,
	output logic [paci_pkg::MOI_W-1:0]    moment_of_inertia,
	output logic                          degenerate
);
	import paci_pkg::*;

	localparam int SH = COORD_W - COORD_BITS;
	localparam logic [NUM_W-1:0] CMAX = NUM_W'((64'd1 << (COORD_BITS - 1)) - 1);
	localparam logic [NUM_W-1:0] CMIN_MAG = NUM_W'(64'd1 << (COORD_BITS - 1));
	localparam logic [NUM_W-1:0] MOI_MAX = NUM_W'((64'd1 << MOI_W) - 1);

	logic [MASS_W-1:0] mass_q;
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic have_q;
	logic signed [COORD_W-1:0] xs, ys;
	logic signed [COORD_W-1:0] ax, ay, bx, by;

	// edge pipeline registers
	logic signed [2*COORD_W-1:0] p_cab_s1, p_cba_s1, p_dx_s1, p_dy_s1;
	logic signed [2*COORD_W-1:0] sq_ax_s2, sq_ay_s2, sq_bx_s2, sq_by_s2;
	logic signed [2*COORD_W-1:0] p_dx_s2, p_dy_s2;
	logic [2*COORD_W-1:0] ac_s2, ac_s3, ac_s4;
	logic signed [COORD_W:0] sx_s2, sy_s2;
	logic [2*COORD_W+1:0] q_s3;
	logic signed [3*COORD_W+1:0] wxp_s3, wyp_s3, wxp_s4, wyp_s4;
	logic [4*COORD_W+1:0] d_s4;
	logic signed [2*COORD_W:0] cdiff;
	logic signed [2*COORD_W+3:0] qsum;

	// accumulators
	logic [CROSS_W-1:0] cross_q;
	logic signed [WSUM_W-1:0] wx_q, wy_q;
	logic [DOT_W-1:0] dot_q;
	logic [CROSS_W:0] cross_nx;
	logic signed [WSUM_W:0] wx_nx, wy_nx;
	logic [DOT_W:0] dot_nx;

	// final stage
	logic [NUM_W-1:0] prod_q;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [DEN_W-1:0] div_den;
	logic div_done;
	logic [WSUM_W-1:0] wx_mag, wy_mag;
	logic [DEN_W-1:0] s3, s6;
	logic signed [COORD_W-1:0] cx_q, cy_q, csat;
	logic [MOI_W-1:0] moi_q;
	logic neg_sel;
	logic out_valid_q;

	// vertex sign extension from the low coordinate bits
	always_comb begin
		xs = $signed(vx << SH) >>> SH;
		ys = $signed(vy << SH) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_W'(1);
		end else if (cfg_we) begin
			mass_q <= cfg_mass;
		end
	end

	// vertex capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			have_q    <= 1'b0;
		end else if (cmd.load_vertex) begin
			cur_x_q  <= xs;
			cur_y_q  <= ys;
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			if (!have_q) begin
				first_x_q <= xs;
				first_y_q <= ys;
				have_q    <= 1'b1;
			end
		end else if (cmd.load_out) begin
			have_q <= 1'b0;
		end
	end

	// edge endpoints: open edge prev->cur, closing edge cur->first
	always_comb begin
		ax = cmd.close_sel ? cur_x_q : prev_x_q;
		ay = cmd.close_sel ? cur_y_q : prev_y_q;
		bx = cmd.close_sel ? first_x_q : cur_x_q;
		by = cmd.close_sel ? first_y_q : cur_y_q;
		cdiff = (2*COORD_W+1)'(p_cab_s1) - (2*COORD_W+1)'(p_cba_s1);
		qsum = (2*COORD_W+4)'(sq_ax_s2) + (2*COORD_W+4)'(sq_ay_s2)
			+ (2*COORD_W+4)'(sq_bx_s2) + (2*COORD_W+4)'(sq_by_s2)
			+ (2*COORD_W+4)'(p_dx_s2) + (2*COORD_W+4)'(p_dy_s2);
	end

	// edge step 1: cross and mixed products
	always_ff @(posedge clk) begin
		if (cmd.e1) begin
			p_cab_s1 <= ax * by;
			p_cba_s1 <= bx * ay;
			p_dx_s1  <= ax * bx;
			p_dy_s1  <= ay * by;
		end
		// step 2: squares, absolute cross, coordinate sums
		if (cmd.e2) begin
			sq_ax_s2 <= ax * ax;
			sq_ay_s2 <= ay * ay;
			sq_bx_s2 <= bx * bx;
			sq_by_s2 <= by * by;
			p_dx_s2  <= p_dx_s1;
			p_dy_s2  <= p_dy_s1;
			ac_s2    <= (2*COORD_W)'(cdiff < 0 ? -cdiff : cdiff);
			sx_s2    <= (COORD_W+1)'(ax) + (COORD_W+1)'(bx);
			sy_s2    <= (COORD_W+1)'(ay) + (COORD_W+1)'(by);
		end
		// step 3: dot term and weighted coordinates
		if (cmd.e3) begin
			q_s3   <= (2*COORD_W+2)'(qsum);
			ac_s3  <= ac_s2;
			wxp_s3 <= sx_s2 * $signed({1'b0, ac_s2});
			wyp_s3 <= sy_s2 * $signed({1'b0, ac_s2});
		end
		// step 4: weighted dot product
		if (cmd.e4) begin
			d_s4   <= ac_s3 * q_s3;
			ac_s4  <= ac_s3;
			wxp_s4 <= wxp_s3;
			wyp_s4 <= wyp_s3;
		end
	end

	// saturating accumulate
	always_comb begin
		cross_nx = {1'b0, cross_q} + (CROSS_W+1)'(ac_s4);
		wx_nx    = (WSUM_W+1)'(wx_q) + (WSUM_W+1)'(wxp_s4);
		wy_nx    = (WSUM_W+1)'(wy_q) + (WSUM_W+1)'(wyp_s4);
		dot_nx   = {1'b0, dot_q} + (DOT_W+1)'(d_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q <= '0;
			wx_q    <= '0;
			wy_q    <= '0;
			dot_q   <= '0;
		end else if (cmd.load_out) begin
			cross_q <= '0;
			wx_q    <= '0;
			wy_q    <= '0;
			dot_q   <= '0;
		end else if (cmd.e5) begin
			cross_q <= cross_nx[CROSS_W] ? '1 : cross_nx[CROSS_W-1:0];
			if (wx_nx[WSUM_W] != wx_nx[WSUM_W-1]) begin
				wx_q <= {wx_nx[WSUM_W], {(WSUM_W-1){~wx_nx[WSUM_W]}}};
			end else begin
				wx_q <= wx_nx[WSUM_W-1:0];
			end
			if (wy_nx[WSUM_W] != wy_nx[WSUM_W-1]) begin
				wy_q <= {wy_nx[WSUM_W], {(WSUM_W-1){~wy_nx[WSUM_W]}}};
			end else begin
				wy_q <= wy_nx[WSUM_W-1:0];
			end
			dot_q <= dot_nx[DOT_W] ? '1 : dot_nx[DOT_W-1:0];
		end
	end

	// divider operands
	always_comb begin
		wx_mag  = wx_q[WSUM_W-1] ? WSUM_W'(-wx_q) : wx_q;
		wy_mag  = wy_q[WSUM_W-1] ? WSUM_W'(-wy_q) : wy_q;
		s3      = {3'b000, cross_q} + {2'b00, cross_q, 1'b0};
		s6      = {s3[DEN_W-2:0], 1'b0};
		div_num = prod_q;
		div_den = s6;
		case (cmd.div_sel)
			DSEL_X: begin
				div_num = NUM_W'(wx_mag);
				div_den = s3;
			end
			DSEL_Y: begin
				div_num = NUM_W'(wy_mag);
				div_den = s3;
			end
			default: begin
				div_num = prod_q;
				div_den = s6;
			end
		endcase
	end

	paci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// centroid clamp to the signed coordinate range
	always_comb begin
		neg_sel = cmd.cap_x ? wx_q[WSUM_W-1] : wy_q[WSUM_W-1];
		if (neg_sel) begin
			if (div_quot > CMIN_MAG) begin
				csat = COORD_W'(-CMIN_MAG);
			end else begin
				csat = COORD_W'(-div_quot);
			end
		end else begin
			if (div_quot > CMAX) begin
				csat = COORD_W'(CMAX);
			end else begin
				csat = COORD_W'(div_quot);
			end
		end
	end

	// mass times dot sum in two partial products, then capture results
	always_ff @(posedge clk) begin
		if (cmd.mm1) begin
			prod_q <= NUM_W'(mass_q * dot_q[DOT_W/2-1:0]);
		end else if (cmd.mm2) begin
			prod_q <= prod_q + (NUM_W'(mass_q * dot_q[DOT_W-1:DOT_W/2]) << (DOT_W/2));
		end
		if (cmd.cap_x) begin
			cx_q <= csat;
		end
		if (cmd.cap_y) begin
			cy_q <= csat;
		end
		if (cmd.cap_i) begin
			moi_q <= (div_quot > MOI_MAX) ? '1 : div_quot[MOI_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			degenerate <= (cross_q == '0);
			if (cross_q == '0) begin
				area_half_units   <= '0;
				centroid_x        <= '0;
				centroid_y        <= '0;
				moment_of_inertia <= '0;
			end else begin
				area_half_units   <= cross_q[CROSS_W-1] ? '1 : cross_q[AREA_W-1:0];
				centroid_x        <= cx_q;
				centroid_y        <= cy_q;
				moment_of_inertia <= moi_q;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.have_vertex = have_q;
	assign stat.cross_zero  = (cross_q == '0);
	assign stat.div_done    = div_done;
	assign stat.out_free    = !out_valid_q || out_ready;

endmodule

// ===== rtl/paci_ctrl.sv =====
`timescale 1ns / 1ps
module paci_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  paci_pkg::stat_t  stat,
	output paci_pkg::cmd_t   cmd
);
	import paci_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_E1   = 4'd1;
	localparam logic [3:0] S_E2   = 4'd2;
	localparam logic [3:0] S_E3   = 4'd3;
	localparam logic [3:0] S_E4   = 4'd4;
	localparam logic [3:0] S_E5   = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_DXS  = 4'd7;
	localparam logic [3:0] S_DXW  = 4'd8;
	localparam logic [3:0] S_DYS  = 4'd9;
	localparam logic [3:0] S_DYW  = 4'd10;
	localparam logic [3:0] S_MM1  = 4'd11;
	localparam logic [3:0] S_MM2  = 4'd12;
	localparam logic [3:0] S_DIS  = 4'd13;
	localparam logic [3:0] S_DIW  = 4'd14;
	localparam logic [3:0] S_OUT  = 4'd15;

	logic [3:0] state_q, state_nx;
	logic last_q, close_q;
	logic accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_nx      = state_q;
		cmd           = '0;
		cmd.close_sel = close_q;
		cmd.div_sel   = DSEL_I;
		case (state_q)
			S_IDLE: begin
				cmd.load_vertex = accept;
				if (accept && (stat.have_vertex || in_last)) begin
					state_nx = S_E1;
				end
			end
			S_E1: begin
				cmd.e1   = 1'b1;
				state_nx = S_E2;
			end
			S_E2: begin
				cmd.e2   = 1'b1;
				state_nx = S_E3;
			end
			S_E3: begin
				cmd.e3   = 1'b1;
				state_nx = S_E4;
			end
			S_E4: begin
				cmd.e4   = 1'b1;
				state_nx = S_E5;
			end
			S_E5: begin
				cmd.e5 = 1'b1;
				if (close_q) begin
					state_nx = S_FIN;
				end else if (last_q) begin
					state_nx = S_E1;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_FIN: begin
				state_nx = stat.cross_zero ? S_OUT : S_DXS;
			end
			S_DXS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_X;
				state_nx      = S_DXW;
			end
			S_DXW: begin
				cmd.cap_x = stat.div_done;
				if (stat.div_done) begin
					state_nx = S_DYS;
				end
			end
			S_DYS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_Y;
				state_nx      = S_DYW;
			end
			S_DYW: begin
				cmd.cap_y = stat.div_done;
				if (stat.div_done) begin
					state_nx = S_MM1;
				end
			end
			S_MM1: begin
				cmd.mm1  = 1'b1;
				state_nx = S_MM2;
			end
			S_MM2: begin
				cmd.mm2  = 1'b1;
				state_nx = S_DIS;
			end
			S_DIS: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIW;
			end
			S_DIW: begin
				cmd.cap_i = stat.div_done;
				if (stat.div_done) begin
					state_nx = S_OUT;
				end
			end
			S_OUT: begin
				cmd.load_out = stat.out_free;
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
			close_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				last_q  <= in_last;
				close_q <= in_last && !stat.have_vertex;
			end else if (state_q == S_E5 && !close_q && last_q) begin
				close_q <= 1'b1;
			end
		end
	end

	// the closing edge runs only for a polygon marked last
	a_close_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E1 && close_q) |-> last_q)
		else $error("closing edge without last vertex");

	// the divider is started only from the start states
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (state_q == S_DXS || state_q == S_DYS || state_q == S_DIS))
		else $error("divider start outside a start state");

	// a result is loaded only into a free output register, then control idles
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (stat.out_free ##1 state_q == S_IDLE))
		else $error("result load into busy output register");

	// no vertex is taken while a polygon is being finished
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> !in_ready || (state_q == S_IDLE))
		else $error("vertex accepted during final computation");

endmodule

// ===== rtl/polygon_area_centroid_inertia_unit.sv =====
`timescale 1ns / 1ps
// sequence: a vertex that closes no polygon is accepted, then runs edge pass E1 to E5
// (a first vertex is only stored); a last vertex runs that pass if it has a predecessor,
// then the closing edge pass, a check state, three runs of the shared 70-step restoring
// divider and multiply states MM1 and MM2, then the output load once the register is free;
// a degenerate polygon skips divider and multiply; vertices are taken only while idle
// reset: asynchronous, active low; accumulators clear, body mass returns to 1
module polygon_area_centroid_inertia_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // vertex_x, vertex_y
	input  logic        s_axis_tlast,   // last_vertex
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // area_half_units, centroid_x, centroid_y,
	                                    // moment_of_inertia, zero fill
	output logic        m_axis_tuser,   // degenerate
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data        // body_mass
);
	import paci_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [AREA_W-1:0]  area;
	logic [COORD_W-1:0] cx, cy;
	logic [MOI_W-1:0]   moi;

	assign cfg_ready = 1'b1;

	paci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	paci_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.vx                (s_axis_tdata[11:0]),
		.vy                (s_axis_tdata[23:12]),
		.cfg_we            (cfg_valid),
		.cfg_mass          (cfg_data),
		.out_ready         (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.area_half_units   (area),
		.centroid_x        (cx),
		.centroid_y        (cy),
		.moment_of_inertia (moi),
		.degenerate        (m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, moi, cy, cx, area};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import paci_pkg::*;

	localparam longint CROSS_LIM   = 64'hFFFF_FFFF;
	localparam longint WSUM_LIM    = 64'hFFF_FFFF_FFFF;
	localparam longint unsigned DOT_LIM = 64'h3FF_FFFF_FFFF_FFFF;
	localparam longint unsigned AREA_LIM = 64'h7FFF_FFFF;
	localparam longint unsigned MOI_LIM  = 64'h3_FFFF_FFFF;
	localparam int DRAIN_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [MOI_W-1:0]   moi;
		logic               degen;
	} poly_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // vertex_x, vertex_y
	logic        s_axis_tlast;   // last_vertex
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;   // area_half_units, centroid_x, centroid_y, moment_of_inertia
	logic        m_axis_tuser;   // degenerate
	logic        cfg_valid;
	logic        cfg_ready;
	logic [11:0] cfg_data;       // body_mass

	polygon_area_centroid_inertia_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	longint unsigned mass_reg;
	longint first_px, first_py, prev_px, prev_py;
	bit     started;
	longint cross_acc, wx_acc, wy_acc;
	longint unsigned dot_acc;

	poly_result_t expected_polys[$];
	int  fail_count;
	int  vertex_count, degen_count, result_count;
	int  snd_idle, rcv_stall;
	longint cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void clear_polygon();
		first_px = 0; first_py = 0; prev_px = 0; prev_py = 0;
		started = 0;
		cross_acc = 0; wx_acc = 0; wy_acc = 0; dot_acc = 0;
	endfunction

	// one origin-fan triangle
	function automatic void add_edge(longint ax, longint ay, longint bx, longint by);
		longint c, ac, q;
		longint unsigned d;
		c = ax * by - bx * ay;
		ac = c < 0 ? -c : c;
		q = ax * ax + ay * ay + bx * bx + by * by + ax * bx + ay * by;
		d = longint'(ac) * longint'(q);
		cross_acc = clamp(cross_acc + ac, 0, CROSS_LIM);
		wx_acc = clamp(wx_acc + (ax + bx) * ac, -WSUM_LIM - 1, WSUM_LIM);
		wy_acc = clamp(wy_acc + (ay + by) * ac, -WSUM_LIM - 1, WSUM_LIM);
		dot_acc = dot_acc + d;
		if (dot_acc > DOT_LIM)
			dot_acc = DOT_LIM;
	endfunction

	// accumulate one vertex, push the polygon result on the last one
	function automatic void predict_vertex(logic signed [COORD_W-1:0] vx,
			logic signed [COORD_W-1:0] vy, logic last);
		longint x, y, s3, cxl, cyl;
		longint unsigned s6, qd, rd, inert;
		poly_result_t r;
		x = vx;
		y = vy;
		if (!started) begin
			first_px = x; first_py = y; started = 1;
		end else begin
			add_edge(prev_px, prev_py, x, y);
		end
		prev_px = x; prev_py = y;
		if (!last)
			return;
		add_edge(x, y, first_px, first_py);
		r = '0;
		if (cross_acc == 0) begin
			r.degen = 1'b1;
		end else begin
			s3 = cross_acc * 3;
			s6 = cross_acc * 6;
			cxl = clamp(wx_acc / s3, -2048, 2047);
			cyl = clamp(wy_acc / s3, -2048, 2047);
			qd = dot_acc / s6;
			rd = dot_acc % s6;
			if (qd > MOI_LIM) begin
				inert = mass_reg != 0 ? MOI_LIM : 0;
			end else begin
				inert = mass_reg * qd + (mass_reg * rd) / s6;
				if (inert > MOI_LIM)
					inert = MOI_LIM;
			end
			r.area = AREA_W'(longint'(cross_acc) > AREA_LIM ? AREA_LIM : cross_acc);
			r.cx = cxl[COORD_W-1:0];
			r.cy = cyl[COORD_W-1:0];
			r.moi = inert[MOI_W-1:0];
		end
		expected_polys.push_back(r);
		clear_polygon();
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// result check
	always @(posedge clk) begin
		poly_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.area  = m_axis_tdata[30:0];
			got.cx    = m_axis_tdata[42:31];
			got.cy    = m_axis_tdata[54:43];
			got.moi   = m_axis_tdata[88:55];
			got.degen = m_axis_tuser;
			if (expected_polys.size() == 0) begin
				report_mismatch("result with no polygon pending");
			end else begin
				want = expected_polys.pop_front();
				result_count++;
				if (got.degen) degen_count++;
				if (got.area !== want.area)
					report_mismatch($sformatf("area %0d want %0d", got.area, want.area));
				if (got.cx !== want.cx)
					report_mismatch($sformatf("centroid_x %0d want %0d", got.cx, want.cx));
				if (got.cy !== want.cy)
					report_mismatch($sformatf("centroid_y %0d want %0d", got.cy, want.cy));
				if (got.moi !== want.moi)
					report_mismatch($sformatf("inertia %0d want %0d", got.moi, want.moi));
				if (got.degen !== want.degen)
					report_mismatch($sformatf("degenerate %0b want %0b", got.degen,
						want.degen));
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rcv_stall);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// one vertex transfer; tvalid stays high unless the sender goes idle
	task automatic send_vertex(logic signed [COORD_W-1:0] vx,
			logic signed [COORD_W-1:0] vy, logic last);
		if ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {vy, vx};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		vertex_count++;
		predict_vertex(vx, vy, last);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_polys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mass(logic [MASS_W-1:0] m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mass_reg = m;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
		case (mode)
			0: return COORD_W'($urandom_range(4095));
			1: return COORD_W'($urandom_range(127) - 64);
			default: return $urandom_range(1) ? 12'sh7FF : 12'sh800;
		endcase
	endfunction

	task automatic send_random_polygon();
		int n, mode;
		n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 9);
		mode = $urandom_range(9) < 5 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(mode), rand_coord(mode), i == n - 1);
	endtask

	task automatic test_directed();
		snd_idle = 0; rcv_stall = 0;
		// triangle around the origin
		send_vertex(12'sd160, 12'sd0, 0);
		send_vertex(-12'sd80, 12'sd140, 0);
		send_vertex(-12'sd80, -12'sd140, 1);
		// square on the coordinate extremes
		send_vertex(12'sh800, 12'sh800, 0);
		send_vertex(12'sh7FF, 12'sh800, 0);
		send_vertex(12'sh7FF, 12'sh7FF, 0);
		send_vertex(12'sh800, 12'sh7FF, 1);
		// lone last vertex
		send_vertex(12'sd37, -12'sd99, 1);
		// collinear points through the origin
		send_vertex(12'sd10, 12'sd20, 0);
		send_vertex(-12'sd30, -12'sd60, 0);
		send_vertex(12'sd50, 12'sd100, 1);
		// two vertices
		send_vertex(12'sd300, 12'sd5, 0);
		send_vertex(-12'sd7, 12'sd400, 1);
		// polygon off the origin, centroid pulled to a corner
		send_vertex(12'sh7FF, 12'sh7FF, 0);
		send_vertex(12'sh7F0, 12'sh7FF, 0);
		send_vertex(12'sh7FF, 12'sh7F0, 1);
		// concave shape
		send_vertex(12'sd100, 12'sd0, 0);
		send_vertex(12'sd0, 12'sd10, 0);
		send_vertex(-12'sd100, 12'sd0, 0);
		send_vertex(12'sd0, 12'sd100, 1);
	endtask

	task automatic test_mass_settings();
		logic [MASS_W-1:0] masses[3] = '{12'd0, 12'hFFF, 12'd1};
		foreach (masses[i]) begin
			write_mass(masses[i]);
			send_vertex(12'sh7FF, 12'sh800, 0);
			send_vertex(12'sh7FF, 12'sh7FF, 0);
			send_vertex(12'sh800, 12'sh000, 1);
		end
	endtask

	task automatic test_random_phase(int idle, int stall, logic [MASS_W-1:0] m,
			int items);
		int start;
		write_mass(m);
		snd_idle = idle; rcv_stall = stall;
		start = vertex_count;
		while (vertex_count - start < items)
			send_random_polygon();
	endtask

	task automatic test_pressure();
		snd_idle = 0; rcv_stall = 64;
		send_random_polygon();
		s_axis_tvalid <= 1'b0;
		while (expected_polys.size() != 0) @(posedge clk);
		send_random_polygon();
		send_random_polygon();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fail_count = 0; vertex_count = 0;
		degen_count = 0; result_count = 0; cycle_count = 0;
		snd_idle = 0; rcv_stall = 0;
		mass_reg = 1;
		clear_polygon();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mass_settings();
		test_random_phase(0, 0, MASS_W'($urandom_range(4095)), 180);
		test_random_phase(64, 0, 12'hFFF, 180);
		test_random_phase(0, 64, 12'd0, 180);
		test_random_phase(11, 11, MASS_W'($urandom_range(4095)), 180);
		test_pressure();
		wait_drained();

		$display("covered %0d vertices, %0d polygon results (%0d degenerate)",
			vertex_count, result_count, degen_count);
		$display("body mass extremes, idle and stall phases, drained-pipe pause");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
